// ----- hw/rtl/bst_pkg.sv -----
// shared types and constants of the bencode stream tokenizer
package bst_pkg;

  // token codes on the result channel
  typedef enum logic [2:0] {
    EV_INT   = 3'd0,
    EV_LIST  = 3'd1,
    EV_DICT  = 3'd2,
    EV_CLOSE = 3'd3,
    EV_HDR   = 3'd4,
    EV_BYTE  = 3'd5,
    EV_ERROR = 3'd6
  } event_t;

  // error codes reported with an error token
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_DIGIT = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_OVERFLOW  = 3'd4,
    ERR_UNDERFLOW = 3'd5,
    ERR_KEY       = 3'd6
  } err_t;

  // stack entry: bit 0 marks a dictionary, bit 1 a dictionary awaiting a value
  typedef logic [1:0] entry_t;
  localparam entry_t ENTRY_KEY_SLOT   = 2'b01;
  localparam entry_t ENTRY_VALUE_SLOT = 2'b11;

  // stream characters
  localparam logic [7:0] CH_INT   = 8'h69; // i
  localparam logic [7:0] CH_LIST  = 8'h6C; // l
  localparam logic [7:0] CH_DICT  = 8'h64; // d
  localparam logic [7:0] CH_END   = 8'h65; // e
  localparam logic [7:0] CH_COLON = 8'h3A; // :
  localparam logic [7:0] CH_MINUS = 8'h2D; // -
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // numeric limits
  localparam logic [31:0] INT_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [35:0] INT_MAG_MAX = 36'h0_8000_0000;

  // stack operations requested by the parser
  typedef struct packed {
    logic clear;
    logic push;
    logic push_dict;
    logic pop;
    logic toggle;
  } stk_req_t;

  // one token, without the depth
  typedef struct packed {
    event_t             ev;
    logic signed [31:0] int_value;
    logic [31:0]        str_length;
    logic [7:0]         payload_byte;
    logic               last_byte;
    logic               is_key;
    logic               top_done;
    err_t               error_code;
  } res_t;

endpackage

// ----- hw/rtl/bst_in_if.sv -----
// request channel carrying stream bytes
interface bst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// ----- hw/rtl/bst_out_if.sv -----
// request channel carrying tokens
interface bst_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic signed [31:0] int_value;
  logic [31:0]        str_length;
  logic [7:0]         payload_byte;
  logic               last_byte;
  logic               is_key;
  logic [5:0]         nest_depth;
  logic               top_done;
  logic [2:0]         error_code;

  modport source (output valid, output event_res, output int_value, output str_length,
                  output payload_byte, output last_byte, output is_key,
                  output nest_depth, output top_done, output error_code, input ready);
  modport sink (input valid, input event_res, input int_value, input str_length,
                input payload_byte, input last_byte, input is_key,
                input nest_depth, input top_done, input error_code, output ready);
endinterface

// ----- hw/rtl/bst_ram.sv -----
// generic single write, single read ram with registered read data
module bst_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/bst_stack.sv -----
// container stack: top entry in a register, lower entries in ram with prefetch
module bst_stack
  import bst_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  localparam int SPW = $clog2(STACK_DEPTH + 1),
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  stk_req_t       req,
  output logic [SPW-1:0] sp_cur,
  output entry_t         top_cur,
  output logic [SPW-1:0] sp_next
);

  logic [SPW-1:0] sp;
  entry_t         top;
  entry_t         top_next;
  entry_t         base;
  entry_t         below;
  entry_t         rdata;
  entry_t         fwd_data;
  logic           fwd;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;

  // view of the stack after an optional restart
  assign sp_cur  = req.clear ? '0 : sp;
  assign top_cur = top;

  // entry just below the top, with bypass of a same-cycle write
  assign below = fwd ? fwd_data : rdata;

  // depth and top entry after this request
  always_comb begin
    sp_next = sp;
    if (fire) begin
      if (req.push) begin
        sp_next = sp_cur + SPW'(1);
      end else if (req.pop) begin
        sp_next = sp_cur - SPW'(1);
      end else begin
        sp_next = sp_cur;
      end
    end
    base = req.pop ? below : top;
    top_next = base;
    if (req.toggle && base[0]) begin
      top_next = base ^ 2'b10;
    end
    if (req.push) begin
      top_next = {1'b0, req.push_dict};
    end
  end

  // old top goes to ram on a push; prefetch the entry under the new top
  assign we    = fire && req.push && (sp_cur != '0);
  assign waddr = AW'(sp_cur - SPW'(1));
  assign raddr = (sp_next >= SPW'(2)) ? AW'(sp_next - SPW'(2)) : '0;

  bst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top),
    .raddr (raddr),
    .rdata (rdata)
  );

  // depth, top entry and bypass registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      fwd <= 1'b0;
    end else begin
      sp  <= sp_next;
      fwd <= we && (waddr == raddr);
    end
    fwd_data <= top;
    if (fire) begin
      top <= top_next;
    end
  end

  // depth never passes the stack size
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack depth beyond size");

  // a push leaves a non-empty stack
  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    fire && req.push |=> sp != '0)
    else $error("push left stack empty");

endmodule

// ----- hw/rtl/bst_parse.sv -----
// byte decoder: parse mode, number accumulators and token building
module bst_parse
  import bst_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     data_byte,
  input  logic           restart,
  input  logic [SPW-1:0] sp_cur,
  input  entry_t         top_cur,
  output stk_req_t       req,
  output logic           res_valid,
  output res_t           res
);

  typedef enum logic [1:0] {
    MODE_VALUE,
    MODE_INT,
    MODE_LEN,
    MODE_STR
  } mode_t;

  mode_t       mode;
  mode_t       mode_eff;
  mode_t       mode_next;
  logic [31:0] int_accum;
  logic [31:0] int_accum_next;
  logic        neg;
  logic        neg_next;
  logic [31:0] len_accum;
  logic [31:0] len_accum_next;
  logic [31:0] remain;
  logic [31:0] remain_next;
  logic [31:0] remain_dec;
  logic        sticky;
  logic        sticky_eff;
  logic        sticky_next;
  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] int_x10;
  logic [35:0] len_x10;
  logic        key_slot;
  logic        wants_value;
  logic        fail;
  err_t        fail_code;

  // byte classes and the times-ten accumulate
  assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit       = data_byte[3:0];
  assign int_x10     = {1'b0, int_accum, 3'b000} + {3'b000, int_accum, 1'b0} + {32'd0, digit};
  assign len_x10     = {1'b0, len_accum, 3'b000} + {3'b000, len_accum, 1'b0} + {32'd0, digit};
  assign key_slot    = (sp_cur != '0) && (top_cur == ENTRY_KEY_SLOT);
  assign wants_value = (sp_cur != '0) && (top_cur == ENTRY_VALUE_SLOT);
  assign remain_dec  = (remain != '0) ? remain - 32'd1 : '0;
  assign mode_eff    = restart ? MODE_VALUE : mode;
  assign sticky_eff  = restart ? 1'b0 : sticky;

  // per-byte decision
  always_comb begin
    mode_next      = mode_eff;
    int_accum_next = int_accum;
    neg_next       = neg;
    len_accum_next = len_accum;
    remain_next    = remain;
    sticky_next    = sticky_eff;
    res_valid      = 1'b0;
    res            = '0;
    req            = '0;
    req.clear      = restart;
    fail           = 1'b0;
    fail_code      = ERR_NONE;
    if (!sticky_eff) begin
      unique case (mode_eff)
        MODE_INT: begin
          if (data_byte == CH_END) begin
            if (!neg && (int_accum > INT_POS_MAX)) begin
              fail      = 1'b1;
              fail_code = ERR_RANGE;
            end else begin
              mode_next     = MODE_VALUE;
              res_valid     = 1'b1;
              res.ev        = EV_INT;
              res.int_value = neg ? -int_accum : int_accum;
              res.top_done  = (sp_cur == '0);
              req.toggle    = 1'b1;
            end
          end else if (data_byte == CH_MINUS) begin
            neg_next = 1'b1;
          end else if (!is_digit) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_DIGIT;
          end else if (int_x10 > INT_MAG_MAX) begin
            fail      = 1'b1;
            fail_code = ERR_RANGE;
          end else begin
            int_accum_next = int_x10[31:0];
          end
        end
        MODE_LEN: begin
          if (data_byte == CH_COLON) begin
            res_valid      = 1'b1;
            res.ev         = EV_HDR;
            res.is_key     = key_slot;
            res.str_length = len_accum;
            if (len_accum == '0) begin
              mode_next    = MODE_VALUE;
              res.top_done = (sp_cur == '0);
              req.toggle   = 1'b1;
            end else begin
              mode_next   = MODE_STR;
              remain_next = len_accum;
            end
          end else if (!is_digit) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_DIGIT;
          end else if (len_x10[35:32] != '0) begin
            fail      = 1'b1;
            fail_code = ERR_RANGE;
          end else begin
            len_accum_next = len_x10[31:0];
          end
        end
        MODE_STR: begin
          remain_next      = remain_dec;
          res_valid        = 1'b1;
          res.ev           = EV_BYTE;
          res.payload_byte = data_byte;
          res.is_key       = key_slot;
          res.last_byte    = (remain_dec == '0);
          if (remain_dec == '0) begin
            mode_next    = MODE_VALUE;
            res.top_done = (sp_cur == '0);
            req.toggle   = 1'b1;
          end
        end
        MODE_VALUE: begin
          if (data_byte == CH_END) begin
            if (sp_cur == '0) begin
              fail      = 1'b1;
              fail_code = ERR_UNDERFLOW;
            end else if (wants_value) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_LEAD;
            end else begin
              req.pop      = 1'b1;
              req.toggle   = 1'b1;
              res_valid    = 1'b1;
              res.ev       = EV_CLOSE;
              res.top_done = (sp_cur == SPW'(1));
            end
          end else if (key_slot && !is_digit) begin
            fail      = 1'b1;
            fail_code = ERR_KEY;
          end else if (is_digit) begin
            len_accum_next = {28'd0, digit};
            mode_next      = MODE_LEN;
          end else if (data_byte == CH_INT) begin
            int_accum_next = '0;
            neg_next       = 1'b0;
            mode_next      = MODE_INT;
          end else if ((data_byte == CH_LIST) || (data_byte == CH_DICT)) begin
            if (sp_cur >= SPW'(STACK_DEPTH)) begin
              fail      = 1'b1;
              fail_code = ERR_OVERFLOW;
            end else begin
              req.push      = 1'b1;
              req.push_dict = (data_byte == CH_DICT);
              res_valid     = 1'b1;
              res.ev        = (data_byte == CH_DICT) ? EV_DICT : EV_LIST;
            end
          end else begin
            fail      = 1'b1;
            fail_code = ERR_BAD_LEAD;
          end
        end
        default: begin
          mode_next = MODE_VALUE;
        end
      endcase
    end
    // error token: parser halts until a restart
    if (fail) begin
      sticky_next    = 1'b1;
      mode_next      = MODE_VALUE;
      res_valid      = 1'b1;
      res            = '0;
      res.ev         = EV_ERROR;
      res.error_code = fail_code;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_VALUE;
      sticky <= 1'b0;
    end else if (fire) begin
      mode   <= mode_next;
      sticky <= sticky_next;
    end
    if (fire) begin
      int_accum <= int_accum_next;
      neg       <= neg_next;
      len_accum <= len_accum_next;
      remain    <= remain_next;
    end
  end

  // a halted parser always sits waiting for a value
  a_sticky_mode: assert property (@(posedge clk) disable iff (rst)
    sticky |-> mode == MODE_VALUE)
    else $error("halted parser left in number or string mode");

endmodule

// ----- hw/rtl/bencode_stream_tokenizer.sv -----
// top level of the bencode stream tokenizer
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   stream   | in  | data_byte, restart
//   tokens   | out | event_res, int_value, str_length, payload_byte, last_byte,
//            |     | is_key, nest_depth, top_done, error_code
//
// one byte per cycle sustained while tokens are taken; a byte's token passes the
// input register, then decode into the token register
// the container stack keeps its top in a register and prefetches the entry
// below it from ram, so a close never waits on a ram read
// rst is synchronous; it empties the stack and clears the parser halt
// a stalled token register holds the decoder, and the input register then fills
module bencode_stream_tokenizer
  import bst_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input logic    clk,
  input logic    rst,
  bst_in_if.sink    stream,
  bst_out_if.source tokens
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic           s1_valid;
  logic [7:0]     s1_byte;
  logic           s1_restart;
  logic           fire;
  logic           out_valid;
  stk_req_t       req;
  logic [SPW-1:0] sp_cur;
  logic [SPW-1:0] sp_next;
  entry_t         top_cur;
  logic           res_valid;
  res_t           res;
  res_t           out_res;
  logic [5:0]     out_depth;

  // decode proceeds when the token register is free or being drained
  assign fire         = s1_valid && (!out_valid || tokens.ready);
  assign stream.ready = !s1_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (stream.valid && stream.ready) begin
      s1_byte    <= stream.data_byte;
      s1_restart <= stream.restart;
    end
  end

  bst_parse #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (s1_byte),
    .restart   (s1_restart),
    .sp_cur    (sp_cur),
    .top_cur   (top_cur),
    .req       (req),
    .res_valid (res_valid),
    .res       (res)
  );

  bst_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .req     (req),
    .sp_cur  (sp_cur),
    .top_cur (top_cur),
    .sp_next (sp_next)
  );

  // token register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
    if (fire && res_valid) begin
      out_res   <= res;
      out_depth <= 6'(sp_next);
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.event_res    = out_res.ev;
  assign tokens.int_value    = out_res.int_value;
  assign tokens.str_length   = out_res.str_length;
  assign tokens.payload_byte = out_res.payload_byte;
  assign tokens.last_byte    = out_res.last_byte;
  assign tokens.is_key       = out_res.is_key;
  assign tokens.nest_depth   = out_depth;
  assign tokens.top_done     = out_res.top_done;
  assign tokens.error_code   = out_res.error_code;

  // input side stalls only behind a held byte
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> s1_valid)
    else $error("input stalled with empty input register");

  // error code present exactly on error tokens
  a_err_token: assert property (@(posedge clk) disable iff (rst)
    tokens.valid |-> ((out_res.ev == EV_ERROR) == (out_res.error_code != ERR_NONE)))
    else $error("error code does not match token kind");

endmodule

// ----- tb/sv/bencode_stream_tokenizer_checker.sv -----
// token predictor and scoreboard for the bencode stream tokenizer
module bencode_stream_tokenizer_checker
  import bst_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  bst_in_if    stream,
  bst_out_if   tokens,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [1:0] {
    PM_VALUE,
    PM_INT,
    PM_LEN,
    PM_STR
  } parse_mode_t;

  localparam entry_t      ENTRY_LIST = 2'b00;
  localparam logic [63:0] LEN_MAX    = 64'hFFFF_FFFF;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    event_t             ev;
    logic signed [31:0] int_value;
    logic [31:0]        str_length;
    logic [7:0]         payload_byte;
    logic               last_byte;
    logic               is_key;
    logic [5:0]         nest_depth;
    logic               top_done;
    err_t               error_code;
  } token_t;

  // parser state mirrored from the stream
  parse_mode_t mode;
  logic [31:0] int_mag;
  logic        neg;
  logic [31:0] len_acc;
  logic [31:0] remaining;
  entry_t      cstack [STACK_DEPTH];
  int unsigned depth;
  logic        halted;

  token_t expected_tokens[$];
  int     errors = 0;

  function automatic void clear_parser();
    mode      = PM_VALUE;
    int_mag   = '0;
    neg       = 1'b0;
    len_acc   = '0;
    remaining = '0;
    depth     = 0;
    halted    = 1'b0;
  endfunction

  function automatic logic key_slot();
    return depth != 0 && cstack[depth-1] == ENTRY_KEY_SLOT;
  endfunction

  function automatic logic value_slot();
    return depth != 0 && cstack[depth-1] == ENTRY_VALUE_SLOT;
  endfunction

  // a value ended: flag it at top level, or flip the parent dict to its next slot
  function automatic logic finish_value();
    if (depth == 0) return 1'b1;
    if (cstack[depth-1][0]) cstack[depth-1][1] = ~cstack[depth-1][1];
    return 1'b0;
  endfunction

  function automatic token_t blank_token(event_t ev);
    token_t t;
    t = '0;
    t.ev = ev;
    t.nest_depth = 6'(depth);
    return t;
  endfunction

  function automatic token_t raise_error(err_t code);
    token_t t;
    halted = 1'b1;
    mode   = PM_VALUE;
    t = blank_token(EV_ERROR);
    t.error_code = code;
    return t;
  endfunction

  // advance the parser by one byte; returns 1 when a token is due
  function automatic logic decode_byte(input logic [7:0] b, input logic rs, output token_t t);
    logic        dig;
    logic [7:0]  dval;
    logic [63:0] wide;
    logic        key;
    t    = '0;
    dig  = b >= CH_ZERO && b <= CH_NINE;
    dval = b - CH_ZERO;
    if (rs) clear_parser();
    if (halted) return 1'b0;
    case (mode)
      PM_INT: begin
        if (b == CH_END) begin
          if (!neg && int_mag > INT_POS_MAX) begin
            t = raise_error(ERR_RANGE);
            return 1'b1;
          end
          mode = PM_VALUE;
          t = blank_token(EV_INT);
          t.int_value = neg ? (32'd0 - int_mag) : int_mag;
          t.top_done = finish_value();
          return 1'b1;
        end
        if (b == CH_MINUS) begin
          neg = 1'b1;
          return 1'b0;
        end
        if (!dig) begin
          t = raise_error(ERR_BAD_DIGIT);
          return 1'b1;
        end
        wide = 64'(int_mag) * 64'd10 + 64'(dval);
        if (wide > INT_MAG_MAX) begin
          t = raise_error(ERR_RANGE);
          return 1'b1;
        end
        int_mag = wide[31:0];
        return 1'b0;
      end
      PM_LEN: begin
        if (b == CH_COLON) begin
          key = key_slot();
          t = blank_token(EV_HDR);
          t.is_key = key;
          t.str_length = len_acc;
          if (len_acc == 0) begin
            // empty string: the header completes it
            mode = PM_VALUE;
            t.top_done = finish_value();
          end else begin
            remaining = len_acc;
            mode = PM_STR;
          end
          return 1'b1;
        end
        if (!dig) begin
          t = raise_error(ERR_BAD_DIGIT);
          return 1'b1;
        end
        wide = 64'(len_acc) * 64'd10 + 64'(dval);
        if (wide > LEN_MAX) begin
          t = raise_error(ERR_RANGE);
          return 1'b1;
        end
        len_acc = wide[31:0];
        return 1'b0;
      end
      PM_STR: begin
        key = key_slot();
        if (remaining != 0) remaining = remaining - 1;
        t = blank_token(EV_BYTE);
        t.payload_byte = b;
        t.is_key = key;
        t.last_byte = remaining == 0;
        if (t.last_byte) begin
          mode = PM_VALUE;
          t.top_done = finish_value();
        end
        return 1'b1;
      end
      default: begin
        mode = PM_VALUE;
        // close, or a misplaced end marker
        if (b == CH_END) begin
          if (depth == 0) t = raise_error(ERR_UNDERFLOW);
          else if (value_slot()) t = raise_error(ERR_BAD_LEAD);
          else begin
            depth--;
            t = blank_token(EV_CLOSE);
            t.top_done = finish_value();
          end
          return 1'b1;
        end
        if (key_slot() && !dig) begin
          t = raise_error(ERR_KEY);
          return 1'b1;
        end
        if (dig) begin
          len_acc = 32'(dval);
          mode = PM_LEN;
          return 1'b0;
        end
        if (b == CH_INT) begin
          int_mag = '0;
          neg = 1'b0;
          mode = PM_INT;
          return 1'b0;
        end
        if (b == CH_LIST || b == CH_DICT) begin
          if (depth >= STACK_DEPTH) begin
            t = raise_error(ERR_OVERFLOW);
            return 1'b1;
          end
          cstack[depth] = (b == CH_DICT) ? ENTRY_KEY_SLOT : ENTRY_LIST;
          depth++;
          if (b == CH_DICT) t = blank_token(EV_DICT);
          else t = blank_token(EV_LIST);
          return 1'b1;
        end
        t = raise_error(ERR_BAD_LEAD);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic string token_text(token_t t);
    return $sformatf("ev=%0d int=%0d len=%0d byte=%02h last=%b key=%b depth=%0d done=%b err=%0d",
                     t.ev, t.int_value, t.str_length, t.payload_byte, t.last_byte,
                     t.is_key, t.nest_depth, t.top_done, t.error_code);
  endfunction

  function automatic logic same_token(token_t a, token_t b);
    return a.ev === b.ev && a.int_value === b.int_value && a.str_length === b.str_length &&
           a.payload_byte === b.payload_byte && a.last_byte === b.last_byte &&
           a.is_key === b.is_key && a.nest_depth === b.nest_depth &&
           a.top_done === b.top_done && a.error_code === b.error_code;
  endfunction

  // watch both channels, compare tokens against predictions
  always @(posedge clk) begin
    token_t seen;
    token_t want;
    if (rst) begin
      clear_parser();
      expected_tokens.delete();
    end else begin
      if (tokens.valid && tokens.ready) begin
        seen.ev           = event_t'(tokens.event_res);
        seen.int_value    = tokens.int_value;
        seen.str_length   = tokens.str_length;
        seen.payload_byte = tokens.payload_byte;
        seen.last_byte    = tokens.last_byte;
        seen.is_key       = tokens.is_key;
        seen.nest_depth   = tokens.nest_depth;
        seen.top_done     = tokens.top_done;
        seen.error_code   = err_t'(tokens.error_code);
        if (expected_tokens.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) $display("unexpected token: %s", token_text(seen));
        end else begin
          want = expected_tokens.pop_front();
          if (!same_token(want, seen)) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("token mismatch at %0t", $realtime);
              $display("  expected %s", token_text(want));
              $display("  actual   %s", token_text(seen));
            end
          end
        end
      end
      if (stream.valid && stream.ready) begin
        if (decode_byte(stream.data_byte, stream.restart, want))
          expected_tokens = {expected_tokens, want};
      end
    end
    fail_count <= errors;
    pending <= expected_tokens.size();
  end

endmodule

// ----- tb/sv/bencode_stream_tokenizer_tb.sv -----
// stimulus and verdict for the bencode stream tokenizer
module bencode_stream_tokenizer_tb;
  import bst_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int ITEM_TARGET  = 2200;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT      = 5_000_000;

  // open-container kinds used by the value generator
  localparam int OPEN_LIST = 0;
  localparam int OPEN_KEY  = 1;
  localparam int OPEN_VAL  = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } stream_req_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  bst_in_if  stream_if ();
  bst_out_if token_if ();

  stream_req_t req_q[$];
  int          open_q[$];
  int          burst_left = 0;
  int          sent = 0;
  logic        needs_restart = 1'b0;
  int unsigned ready_tick = 0;

  bencode_stream_tokenizer #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .stream(stream_if),
    .tokens(token_if)
  );

  bencode_stream_tokenizer_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream_if),
    .tokens    (token_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("bencode_stream_tokenizer_tb NOT OK");
    $finish;
  end

  // token sink stalls on a rotating pattern
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    case (ready_tick[9:8])
      2'd0:    token_if.ready <= 1'b1;
      2'd1:    token_if.ready <= ready_tick[1:0] != 2'b11;
      2'd2:    token_if.ready <= 1'($urandom_range(0, 1));
      default: token_if.ready <= ready_tick[5:4] != 2'b00;
    endcase
  end

  task automatic put_byte(input logic [7:0] data, input logic rs);
    stream_req_t r;
    r.data = data;
    r.restart = rs;
    req_q = {req_q, r};
  endtask

  task automatic put_text(input string s, input logic rs);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], rs && i == 0);
  endtask

  // integer with extreme magnitudes and minus signs in odd places
  task automatic put_int();
    longint unsigned mag;
    string           digits;
    int              minus_at[$];
    int              n_minus;
    case ($urandom_range(0, 9))
      0:       mag = 0;
      1:       mag = 64'h7FFF_FFFF;
      2:       mag = 64'h8000_0000;
      3:       mag = 64'h8000_0001;
      4:       mag = $urandom();
      5:       mag = 64'd99_999_999_999;
      default: mag = $urandom_range(0, 9999);
    endcase
    if (mag > 64'h7FFF_FFFF) needs_restart = 1'b1;
    digits = $sformatf("%0d", mag);
    if (mag == 0 && $urandom_range(0, 2) == 0) digits = "";
    else if ($urandom_range(0, 7) == 0) digits = {"0", digits};
    n_minus = ($urandom_range(0, 1) == 0) ? 0 :
              (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1);
    repeat (n_minus)
      minus_at = {minus_at,
                  int'(($urandom_range(0, 3) == 0) ? $urandom_range(0, digits.len()) : 0)};
    put_byte(CH_INT, 1'b0);
    for (int p = 0; p <= digits.len(); p++) begin
      foreach (minus_at[m]) if (minus_at[m] == p) put_byte(CH_MINUS, 1'b0);
      if (p < digits.len()) put_byte(digits[p], 1'b0);
    end
    put_byte(CH_END, 1'b0);
  endtask

  // string with a mostly short length and random content
  task automatic put_string();
    int    n;
    string len_txt;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    len_txt = $sformatf("%0d", n);
    if ($urandom_range(0, 9) == 0) len_txt = {"0", len_txt};
    put_text(len_txt, 1'b0);
    put_byte(CH_COLON, 1'b0);
    repeat (n) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // huge or oversized string length, abandoned after a few bytes
  task automatic put_length_probe();
    case ($urandom_range(0, 3))
      0:       put_text("4294967295", 1'b0);
      1:       put_text("4294967296", 1'b0);
      2:       put_text("99999999999", 1'b0);
      default: put_text($sformatf("%0d", $urandom()), 1'b0);
    endcase
    put_byte(CH_COLON, 1'b0);
    repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    needs_restart = 1'b1;
  endtask

  task automatic advance_parent();
    if (open_q.size() > 0 && open_q[$] == OPEN_VAL) open_q[$] = OPEN_KEY;
  endtask

  // one well-formed top-level value of random shape
  task automatic put_value(input int max_depth);
    int start;
    int pick;
    logic crowded;
    start = req_q.size();
    open_q.delete();
    do begin
      crowded = req_q.size() - start > 80;
      if (open_q.size() > 0 && open_q[$] != OPEN_VAL &&
          ($urandom_range(0, 2) == 0 || crowded)) begin
        put_byte(CH_END, 1'b0);
        void'(open_q.pop_back());
        advance_parent();
      end else if (open_q.size() > 0 && open_q[$] == OPEN_KEY) begin
        put_string();
        open_q[$] = OPEN_VAL;
      end else begin
        pick = (open_q.size() >= max_depth || crowded) ? $urandom_range(0, 1)
                                                       : $urandom_range(0, 3);
        case (pick)
          0: begin
            put_int();
            advance_parent();
          end
          1: begin
            put_string();
            advance_parent();
          end
          2: begin
            put_byte(CH_LIST, 1'b0);
            open_q = {open_q, OPEN_LIST};
          end
          default: begin
            put_byte(CH_DICT, 1'b0);
            open_q = {open_q, OPEN_KEY};
          end
        endcase
      end
    end while (open_q.size() > 0);
  endtask

  // deep list nesting up to or one past the stack size
  task automatic put_nest(input int n);
    repeat (n) put_byte(CH_LIST, 1'b0);
    put_int();
    repeat (n) put_byte(CH_END, 1'b0);
    if (n > STACK_DEPTH) needs_restart = 1'b1;
  endtask

  // push queued bytes out in bursts with random gaps
  task automatic send_queued();
    stream_req_t r;
    int          gap;
    while (req_q.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          stream_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      r = req_q.pop_front();
      stream_if.valid     <= 1'b1;
      stream_if.data_byte <= r.data;
      stream_if.restart   <= r.restart;
      @(posedge clk);
      while (!stream_if.ready) @(posedge clk);
      sent++;
      burst_left--;
    end
  endtask

  initial begin
    int   first;
    int   sel;
    int   idx;
    logic rs_now;
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.data_byte = 8'h00;
    stream_if.restart = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: sign handling, empty int, underflow, bad lead, key and bad digit errors, empty string, halt
    put_text("i-5-e", 1'b1);
    put_text("ie", 1'b0);
    put_text("e", 1'b0);
    put_text("i", 1'b0);
    put_text("d1:ae", 1'b1);
    put_text("di", 1'b1);
    put_text("0:", 1'b1);
    put_text("x", 1'b0);
    put_text("i5z", 1'b1);
    put_text("1z", 1'b1);
    put_text("le", 1'b1);
    send_queued();
    needs_restart = 1'b1;

    // random: mostly valid values, some broken ones and noise
    while (sent < ITEM_TARGET) begin
      first = req_q.size();
      rs_now = needs_restart || $urandom_range(0, 7) == 0;
      needs_restart = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 3) put_nest(($urandom_range(0, 1) == 0) ? STACK_DEPTH : STACK_DEPTH + 1);
      else if (sel < 8) begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)), 1'b0);
        needs_restart = 1'b1;
      end else if (sel < 12) put_length_probe();
      else begin
        put_value(8);
        if (sel < 27) begin
          // corrupt one byte or cut the value short
          idx = $urandom_range(first, req_q.size() - 1);
          if ($urandom_range(0, 1) == 0) req_q[idx].data = 8'($urandom_range(0, 255));
          else while (req_q.size() > idx) void'(req_q.pop_back());
          needs_restart = 1'b1;
        end
      end
      if (req_q.size() > first) req_q[first].restart = rs_now;
      send_queued();
    end
    stream_if.valid <= 1'b0;

    // wait for all tokens, then a quiet stretch to catch strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bencode_stream_tokenizer_tb OK");
    end else begin
      $display("bencode_stream_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule
